### src/hacc_pkg.sv
// Shared constants, types and state encoding for the histogram accumulator.
`default_nettype none
package hacc_pkg;
    localparam int NUM_BINS     = 1024;
    localparam int BIN_W        = $clog2(NUM_BINS);
    localparam int HI_W         = BIN_W + 1;
    localparam int COUNT_W      = 32;
    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 42;
    localparam int WIDTH_W      = 15;
    localparam int DIV_W        = 58;
    localparam int STEP_W       = $clog2(DIV_W + 1);
    localparam int PROD_A_W     = SUM_W + WIDTH_W;
    localparam int PROD_B_W     = COUNT_W + WIDTH_W - 1;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_MEAN  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_RMW,
        S_RDV,
        S_MUL1,
        S_MUL2,
        S_MSTART,
        S_MDIV,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

### src/hacc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/hacc_div.sv
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
`default_nettype none
module hacc_div
    import hacc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_W-1:0]   dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    input  wire logic [STEP_W-1:0]  steps,
    output logic                    done,
    output logic      [DIV_W-1:0]   quotient
);
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0] dsr_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   rem_w;
    logic [COUNT_W:0]   diff;

    always_comb
    begin
        rem_w = {rem_reg, quo_reg[DIV_W-1]};
        diff  = rem_w - {1'b0, dsr_reg};
        if (!diff[COUNT_W])
        begin
            rem_next = diff[COUNT_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_w[COUNT_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

### src/histogram_accumulator_with_mean.sv
// From accept to result: add runs a divide to a 16-bit quotient, range check, bin read and
// write-back; read reads it; mean runs S_MUL1, S_MUL2, a 58-bit divide; clear zeroes bins.
// One item is in work at a time; the next is taken in the cycle after its result is loaded.
// A finished result waits in the output register while the next item is taken.
// After reset the bin memory is swept to zero, all 1024 bins, with s_tready low meanwhile;
// bin_width resets to 1 and configuration writes are taken at any time.
`default_nettype none
module histogram_accumulator_with_mean
    import hacc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // sample[15:0], bin_index[25:16], zeros
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // value[31:0], bins_in_use[42:32], zeros
    output logic      [1:0]  m_tuser,   // status[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  width_reg;
    logic [COUNT_W-1:0]  total_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [HI_W-1:0]     hi_reg;
    logic [BIN_W-1:0]    clr_cnt_reg;
    logic [BIN_W-1:0]    bin_reg;
    logic [1:0]          status_reg;
    logic [COUNT_W-1:0]  value_reg;
    logic [PROD_A_W-1:0] prod_a_reg;
    logic [PROD_B_W-1:0] prod_b_reg;
    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [COUNT_W-1:0]  out_value_reg;
    logic [HI_W-1:0]     out_hi_reg;
    // set while the pending result is only the end of the reset sweep
    logic                pend_none_reg;

    logic [1:0]          func;
    logic [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]    bin_index;
    logic [WIDTH_W-1:0]  w_eff;
    logic                accept;
    logic                cfg_wr;

    logic                ram_we;
    logic [BIN_W-1:0]    ram_waddr;
    logic [COUNT_W-1:0]  ram_wdata;
    logic [BIN_W-1:0]    ram_raddr;
    logic [COUNT_W-1:0]  ram_rdata;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [COUNT_W-1:0]  div_divisor;
    logic [STEP_W-1:0]   div_steps;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic                bump;
    logic                out_load;

    assign func      = s_tuser;
    assign sample    = s_tdata[SAMPLE_W-1:0];
    assign bin_index = s_tdata[SAMPLE_W +: BIN_W];
    assign w_eff     = (width_reg == '0) ? WIDTH_W'(1) : width_reg;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {{(32-WIDTH_W){1'b0}}, width_reg};

    // bin count update is allowed only when neither counter is saturated
    assign bump = (ram_rdata != COUNT_MAX) && (total_reg != COUNT_MAX);

    hacc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hacc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        ram_we       = 1'b0;
        ram_waddr    = bin_reg;
        ram_wdata    = ram_rdata + 1'b1;
        ram_raddr    = bin_reg;
        div_start    = 1'b0;
        div_dividend = {sample, {(DIV_W-SAMPLE_W){1'b0}}};
        div_divisor  = {{(COUNT_W-WIDTH_W){1'b0}}, w_eff};
        div_steps    = STEP_W'(SAMPLE_W);
        out_load     = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == BIN_W'(NUM_BINS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = bin_index;
                if (accept)
                begin
                    case (func)
                        FUNC_ADD:
                        begin
                            if (sample[SAMPLE_W-1])
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        FUNC_CLEAR: state_next = S_CLR;
                        FUNC_READ:  state_next = S_RDV;
                        FUNC_MEAN:  state_next = (total_reg == '0) ? S_DONE : S_MUL1;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_DIV:
            begin
                ram_raddr = div_quo[BIN_W-1:0];
                if (div_done)
                begin
                    state_next = (div_quo[SAMPLE_W-1:0] >= SAMPLE_W'(NUM_BINS)) ? S_DONE : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_RMW;
            end
            S_RMW:
            begin
                ram_we     = bump;
                state_next = S_DONE;
            end
            S_RDV:
            begin
                state_next = S_DONE;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod_a_reg) + DIV_W'(prod_b_reg);
                div_divisor  = total_reg;
                div_steps    = STEP_W'(DIV_W);
                state_next   = S_MDIV;
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            width_reg   <= WIDTH_W'(1);
            total_reg   <= '0;
            sum_reg     <= '0;
            hi_reg      <= '0;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            // the reset sweep ends in S_DONE; pend_none_reg keeps it from emitting a result
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                width_reg <= pwdata[WIDTH_W-1:0];
            end
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                total_reg   <= '0;
                sum_reg     <= '0;
                hi_reg      <= '0;
            end
            if (state_reg == S_RMW && bump)
            begin
                total_reg <= total_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(bin_reg);
                if ({1'b0, bin_reg} >= hi_reg)
                begin
                    hi_reg <= {1'b0, bin_reg} + 1'b1;
                end
            end
            if (out_load && !pend_none_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_none_reg <= 1'b1;
        end
        else if (out_load)
        begin
            pend_none_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                status_reg <= (accept && func == FUNC_ADD && sample[SAMPLE_W-1])
                              ? ST_RANGE : ST_OK;
                value_reg  <= '0;
            end
            S_DIV:
            begin
                bin_reg <= div_quo[BIN_W-1:0];
                if (div_done && div_quo[SAMPLE_W-1:0] >= SAMPLE_W'(NUM_BINS))
                begin
                    status_reg <= ST_RANGE;
                end
            end
            S_RMW:
            begin
                if (bump)
                begin
                    value_reg <= ram_rdata + 1'b1;
                end
                else
                begin
                    status_reg <= ST_SAT;
                    value_reg  <= ram_rdata;
                end
            end
            S_RDV:
            begin
                value_reg <= ram_rdata;
            end
            S_MUL1:
            begin
                prod_a_reg <= sum_reg * w_eff;
            end
            S_MUL2:
            begin
                prod_b_reg <= total_reg * w_eff[WIDTH_W-1:1];
            end
            S_MDIV:
            begin
                value_reg <= div_quo[COUNT_W-1:0];
            end
            S_CLR:
            begin
                status_reg <= ST_OK;
                value_reg  <= '0;
            end
            default:
            begin
                value_reg <= value_reg;
            end
        endcase
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_value_reg  <= value_reg;
            out_hi_reg     <= hi_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(48-COUNT_W-HI_W){1'b0}}, out_hi_reg, out_value_reg};

    assert property (@(posedge clk) disable iff (!rst_n) hi_reg <= HI_W'(NUM_BINS))
        else $error("bins_in_use beyond table");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV || state_reg == S_MDIV))
        else $error("divider finished outside a divide state");
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLR || state_reg == S_RMW))
        else $error("bin memory written outside sweep or update");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW && bump) |=> total_reg == $past(total_reg) + 1'b1)
        else $error("total not advanced with bin update");
endmodule
`default_nettype wire
